/* src/sn_pkg.sv */
package sn_pkg;

  localparam int DEPTH_DEF = 64;

  // Fixed datapath widths, sized for a store of DEPTH_DEF entries
  localparam int SCORE_W = 32;
  localparam int SUM_W   = 38;
  localparam int D_W     = 40;
  localparam int A_W     = 29;
  localparam int SQ_W    = 2 * A_W;
  localparam int Q_W     = 64;
  localparam int SH_W    = 5;
  localparam int NS_W    = 8;
  localparam int RES_W   = 48;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_MINMAX = 2'd1;
  localparam logic [1:0] MODE_SUM    = 2'd2;
  localparam logic [1:0] MODE_ZSCORE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } sn_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] norm_score;
    logic [1:0]              status;
    logic                    final_res;
  } sn_out_t;

  typedef struct packed {
    logic wr_en;
    logic first;
    logic acc1;
    logic accm;
    logic norm_step;
    logic accq;
    logic div_start;
    logic div_elem;
    logic sqrt_start;
    logic out_load;
    logic last_res;
    logic ovf;
  } sn_cmd_t;

  typedef struct packed {
    logic degen;
    logic norm_ok;
    logic div_done;
    logic sqrt_done;
  } sn_stat_t;

endpackage

/* src/sn_div.sv */
module sn_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] den_r, den_nxt;
  logic [64:0] rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_sh   = {rem_r[63:0], quo_r[63]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      // one quotient bit per cycle, restoring
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

/* src/sn_sqrt.sv */
module sn_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] v,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [63:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    trial    = res_r + bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      v_nxt    = v;
      res_nxt  = '0;
      bit_nxt  = 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

/* src/sn_dp.sv */
module sn_dp #(
  parameter int DEPTH = sn_pkg::DEPTH_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sn_pkg::sn_cmd_t                    cmd,
  input  logic [ADDR_W-1:0]                  addr,
  input  logic [CNT_W-1:0]                   n,
  input  logic [1:0]                         mode,
  input  logic signed [sn_pkg::SCORE_W-1:0]  in_score,
  output sn_pkg::sn_out_t                    out_data,
  output sn_pkg::sn_stat_t                   st
);

  localparam int D_W = sn_pkg::D_W;
  localparam int A_W = sn_pkg::A_W;

  logic signed [sn_pkg::SCORE_W-1:0] store_r [DEPTH];
  logic signed [sn_pkg::SCORE_W-1:0] rdata_r;

  logic signed [sn_pkg::SCORE_W-1:0] mn_r, mx_r;
  logic signed [sn_pkg::SUM_W-1:0]   sum_r;
  logic [sn_pkg::SUM_W-1:0]          sabs_r;
  logic signed [D_W-1:0]             d_r;
  logic [A_W-1:0]                    a_r;
  logic                              aneg_r;
  logic [sn_pkg::SQ_W-1:0]           sq_r;
  logic [D_W-1:0]                    m_r;
  logic [sn_pkg::SH_W-1:0]           rsh_r, lsh_r;
  logic [sn_pkg::Q_W-1:0]            q_r;
  sn_pkg::sn_out_t                   out_r;

  logic [sn_pkg::SCORE_W-1:0]        s_abs;
  logic signed [sn_pkg::NS_W-1:0]    n_s;
  logic signed [D_W-1:0]             prod;
  logic signed [D_W-1:0]             d_nxt;
  logic [D_W-1:0]                    d_u, d_mag, shifted;
  logic [32:0]                       rng, dif;
  logic [63:0]                       div_num, div_den, quot;
  logic                              div_done, sqrt_done;
  logic [31:0]                       sd;
  logic [sn_pkg::RES_W-1:0]          q48;
  logic signed [sn_pkg::RES_W-1:0]   res;
  logic                              degen;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store_r[addr] <= in_score;
    end
    rdata_r <= store_r[addr];
  end

  always_comb begin
    s_abs   = rdata_r[sn_pkg::SCORE_W-1] ? (~rdata_r + 32'd1) : rdata_r;
    n_s     = sn_pkg::NS_W'(n);
    prod    = n_s * rdata_r;
    d_nxt   = prod - D_W'(sum_r);
    d_u     = d_r;
    d_mag   = d_r[D_W-1] ? (~d_u + D_W'(1)) : d_u;
    shifted = (d_mag >> rsh_r) << lsh_r;
    rng     = {mx_r[31], mx_r} - {mn_r[31], mn_r};
    dif     = {rdata_r[31], rdata_r} - {mn_r[31], mn_r};
  end

  // element pipeline: rdata_r feeds d_r, then a_r and aneg_r, then sq_r
  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    a_r    <= shifted[A_W-1:0];
    aneg_r <= d_r[D_W-1];
    sq_r   <= a_r * a_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc1) begin
      if (cmd.first) begin
        mn_r   <= rdata_r;
        mx_r   <= rdata_r;
        sum_r  <= sn_pkg::SUM_W'(rdata_r);
        sabs_r <= sn_pkg::SUM_W'(s_abs);
      end else begin
        if (rdata_r < mn_r) mn_r <= rdata_r;
        if (rdata_r > mx_r) mx_r <= rdata_r;
        sum_r  <= sum_r + sn_pkg::SUM_W'(rdata_r);
        sabs_r <= sabs_r + sn_pkg::SUM_W'(s_abs);
      end
    end
    if (cmd.accm) begin
      if (cmd.first) begin
        m_r   <= d_mag;
        rsh_r <= '0;
        lsh_r <= '0;
      end else if (d_mag > m_r) begin
        m_r <= d_mag;
      end
    end else if (cmd.norm_step) begin
      if (m_r[D_W-1:A_W] != '0) begin
        m_r   <= m_r >> 1;
        rsh_r <= rsh_r + sn_pkg::SH_W'(1);
      end else begin
        m_r   <= m_r << 1;
        lsh_r <= lsh_r + sn_pkg::SH_W'(1);
      end
    end
    if (cmd.accq) begin
      if (cmd.first) q_r <= sn_pkg::Q_W'(sq_r);
      else q_r <= q_r + sn_pkg::Q_W'(sq_r);
    end
  end

  always_comb begin
    unique case (mode)
      sn_pkg::MODE_NONE:   degen = 1'b0;
      sn_pkg::MODE_MINMAX: degen = (mn_r == mx_r);
      sn_pkg::MODE_SUM:    degen = (sabs_r == '0);
      sn_pkg::MODE_ZSCORE: degen = (m_r == '0);
    endcase
  end

  always_comb begin
    if (!cmd.div_elem) begin
      div_num = q_r;
      div_den = 64'(n);
    end else begin
      unique case (mode)
        sn_pkg::MODE_MINMAX: begin
          div_num = {dif[31:0], 32'h0};
          div_den = 64'(rng);
        end
        sn_pkg::MODE_SUM: begin
          div_num = {s_abs, 32'h0};
          div_den = 64'(sabs_r);
        end
        sn_pkg::MODE_ZSCORE, sn_pkg::MODE_NONE: begin
          div_num = {3'b000, a_r, 32'h0};
          div_den = 64'(sd);
        end
      endcase
    end
  end

  sn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  sn_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .v     (quot),
    .done  (sqrt_done),
    .root  (sd)
  );

  always_comb begin
    q48 = quot[sn_pkg::RES_W-1:0];
    if (mode == sn_pkg::MODE_NONE || degen) begin
      res = {rdata_r, 16'h0};
    end else if (mode == sn_pkg::MODE_ZSCORE && aneg_r) begin
      res = -q48;
    end else begin
      res = q48;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.norm_score <= res;
      out_r.status     <= cmd.ovf ? sn_pkg::ST_TRUNC : (degen ? sn_pkg::ST_DEGEN : sn_pkg::ST_OK);
      out_r.final_res  <= cmd.last_res;
    end
  end

  assign out_data     = out_r;
  assign st.degen     = degen;
  assign st.norm_ok   = (m_r[D_W-1:A_W] == '0) && m_r[A_W-1];
  assign st.div_done  = div_done;
  assign st.sqrt_done = sqrt_done;

endmodule

/* src/sn_ctrl.sv */
module sn_ctrl #(
  parameter int DEPTH = sn_pkg::DEPTH_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  output logic [1:0]        mode,
  output sn_pkg::sn_cmd_t   cmd,
  output logic [ADDR_W-1:0] addr,
  output logic [CNT_W-1:0]  n,
  input  sn_pkg::sn_stat_t  st
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_P1    = 4'd1;
  localparam logic [3:0] S_P2    = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_P3    = 4'd4;
  localparam logic [3:0] S_VDIV  = 4'd5;
  localparam logic [3:0] S_VWAIT = 4'd6;
  localparam logic [3:0] S_SWAIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_ODIV  = 4'd9;
  localparam logic [3:0] S_HOLD  = 4'd10;

  localparam logic [2:0] SETTLE = 3'd4;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [2:0]        sub_r, sub_nxt;
  logic              ovf_r, ovf_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic              at_settle, is_last, has_room;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    sub_nxt   = sub_r;
    ovf_nxt   = ovf_r;
    mode_nxt  = mode_r;
    cmd       = '0;

    at_settle = (sub_r == SETTLE);
    is_last   = (CNT_W'(idx_r) == n_r - CNT_W'(1));
    has_room  = (cnt_r < DEPTH_C);

    cmd.first    = (idx_r == '0);
    cmd.ovf      = ovf_r;
    cmd.last_res = is_last;

    in_ready  = (state_r == S_LOAD);
    out_valid = (state_r == S_HOLD);
    cfg_ready = 1'b1;
    addr      = (state_r == S_LOAD) ? cnt_r[ADDR_W-1:0] : idx_r;

    if (cfg_valid) mode_nxt = cfg_data;

    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (has_room) begin
            cmd.wr_en = 1'b1;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            n_nxt     = has_room ? cnt_r + CNT_W'(1) : cnt_r;
            idx_nxt   = '0;
            sub_nxt   = '0;
            state_nxt = S_P1;
          end
        end
      end
      S_P1: begin
        if (!at_settle) begin
          sub_nxt = sub_r + 3'd1;
        end else begin
          cmd.acc1 = 1'b1;
          sub_nxt  = '0;
          if (is_last) begin
            idx_nxt   = '0;
            state_nxt = (mode_r == sn_pkg::MODE_ZSCORE) ? S_P2 : S_OUT;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
      end
      S_P2: begin
        if (!at_settle) begin
          sub_nxt = sub_r + 3'd1;
        end else begin
          cmd.accm = 1'b1;
          sub_nxt  = '0;
          if (is_last) begin
            idx_nxt   = '0;
            state_nxt = S_NORM;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
      end
      S_NORM: begin
        // all deviations zero: skip straight to pass-through output
        if (st.degen) begin
          state_nxt = S_OUT;
        end else if (st.norm_ok) begin
          state_nxt = S_P3;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_P3: begin
        if (!at_settle) begin
          sub_nxt = sub_r + 3'd1;
        end else begin
          cmd.accq = 1'b1;
          sub_nxt  = '0;
          if (is_last) begin
            idx_nxt   = '0;
            state_nxt = S_VDIV;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
      end
      S_VDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_VWAIT;
      end
      S_VWAIT: begin
        if (st.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (st.sqrt_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!at_settle) begin
          sub_nxt = sub_r + 3'd1;
        end else if (mode_r != sn_pkg::MODE_NONE && !st.degen) begin
          cmd.div_start = 1'b1;
          cmd.div_elem  = 1'b1;
          state_nxt     = S_ODIV;
        end else begin
          cmd.out_load = 1'b1;
          state_nxt    = S_HOLD;
        end
      end
      S_ODIV: begin
        cmd.div_elem = 1'b1;
        if (st.div_done) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_ready) begin
          sub_nxt = '0;
          if (is_last) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            idx_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = S_OUT;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      idx_r   <= '0;
      sub_r   <= '0;
      ovf_r   <= 1'b0;
      mode_r  <= sn_pkg::MODE_NONE;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      idx_r   <= idx_nxt;
      sub_r   <= sub_nxt;
      ovf_r   <= ovf_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign mode = mode_r;
  assign n    = n_r;

endmodule

/* src/score_normalizer.sv */
// Score normalizer. Scores are taken one per cycle into a single-port store of
// DEPTH entries until an item marked last; scores beyond DEPTH are dropped and
// every result of that run carries the truncated status. The block then reads
// the store back, one score at a time per pass: one pass for pass-through,
// min-max and sum modes, three for z-score (plus shift normalization, a variance
// divide and a square root). Results follow in order, one per stored score, each
// produced by a 64-step bit-serial divide (no divide in pass-through or
// degenerate runs) and then held until it is taken. No new score is taken
// until the last result of the run has been delivered. The mode register may be
// written only while idle.
module score_normalizer #(
  parameter int DEPTH = sn_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sn_pkg::sn_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sn_pkg::sn_out_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_data
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sn_pkg::sn_cmd_t   cmd;
  sn_pkg::sn_stat_t  st;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0]  n;
  logic [1:0]        mode;

  sn_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_data.last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .cmd       (cmd),
    .addr      (addr),
    .n         (n),
    .st        (st)
  );

  sn_dp #(.DEPTH(DEPTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .addr     (addr),
    .n        (n),
    .mode     (mode),
    .in_score (in_data.score),
    .out_data (out_data),
    .st       (st)
  );

endmodule
